// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl; gimbal_status_frame_parser takes them in
// depends on nothing; taken in by `include where a module checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== rtl/gsfp_pkg.sv =====
// types and constants of the gimbal status frame parser
// no dependencies; used by gsfp_frame_fsm and gimbal_status_frame_parser
package gsfp_pkg;

  localparam logic [7:0] HDR_BYTE_ONE   = 8'hb0;
  localparam logic [7:0] HDR_BYTE_TWO   = 8'h3b;
  localparam logic [7:0] HDR_BYTE_THREE = 8'h4f;

  // payload positions of the angle bytes: pitch lo/hi, roll lo/hi
  localparam int unsigned PITCH_LO_POS = 6;
  localparam int unsigned PITCH_HI_POS = 7;
  localparam int unsigned ROLL_LO_POS  = 8;
  localparam int unsigned ROLL_HI_POS  = 9;

  localparam int unsigned ANGLE_W = 12;

  typedef enum logic [4:0] {
    PH_HUNT1 = 5'b00001,
    PH_HUNT2 = 5'b00010,
    PH_HUNT3 = 5'b00100,
    PH_DATA  = 5'b01000,
    PH_CSUM  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] pitch;
    logic signed [ANGLE_W-1:0] roll;
  } angles_t;

  typedef struct packed {
    logic hit;      // checksum matched on this step
    logic in_csum;  // parser is waiting for the checksum byte
  } fsm_stat_t;

endpackage

// ===== rtl/gsfp_frame_fsm.sv =====
// frame state machine: header hunt, running sum over header and payload, angle byte capture, checksum compare
// depends on gsfp_pkg
module gsfp_frame_fsm #(
  parameter int unsigned PAYLOAD_LEN = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         rx_byte,
  output gsfp_pkg::fsm_stat_t stat,
  output gsfp_pkg::angles_t   angles
);
  import gsfp_pkg::*;

  localparam int unsigned CNT_W = $clog2(PAYLOAD_LEN + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(PAYLOAD_LEN);
  localparam logic [CNT_W-1:0] P_LO_CNT = CNT_W'(PITCH_LO_POS);
  localparam logic [CNT_W-1:0] P_HI_CNT = CNT_W'(PITCH_HI_POS);
  localparam logic [CNT_W-1:0] R_LO_CNT = CNT_W'(ROLL_LO_POS);
  localparam logic [CNT_W-1:0] R_HI_CNT = CNT_W'(ROLL_HI_POS);

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] payload_count, payload_count_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [7:0]       pitch_lo, pitch_hi, roll_lo, roll_hi;
  logic [CNT_W-1:0] count_inc;

  assign count_inc = payload_count + CNT_W'(1);

  always_comb begin
    phase_next         = phase;
    payload_count_next = payload_count;
    running_sum_next   = running_sum;
    stat.hit           = 1'b0;
    stat.in_csum       = (phase == PH_CSUM);
    unique case (phase)
      PH_HUNT2: begin
        if (rx_byte == HDR_BYTE_TWO) begin
          running_sum_next = running_sum + rx_byte;
          phase_next       = PH_HUNT3;
        end
      end
      PH_HUNT3: begin
        if (rx_byte == HDR_BYTE_THREE) begin
          running_sum_next = running_sum + rx_byte;
          phase_next       = PH_DATA;
        end
      end
      PH_DATA: begin
        running_sum_next   = running_sum + rx_byte;
        payload_count_next = count_inc;
        if (count_inc == LAST_CNT) begin
          phase_next = PH_CSUM;
        end
      end
      PH_CSUM: begin
        phase_next = PH_HUNT1;
        stat.hit   = step && (rx_byte == running_sum);
      end
      default: begin
        if (rx_byte == HDR_BYTE_ONE) begin
          payload_count_next = '0;
          running_sum_next   = rx_byte;
          phase_next         = PH_HUNT2;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT1;
      payload_count <= '0;
      running_sum   <= '0;
    end else if (step) begin
      phase         <= phase_next;
      payload_count <= payload_count_next;
      running_sum   <= running_sum_next;
    end
  end

  // angle bytes: each one sits at a fixed payload position
  always_ff @(posedge clk) begin
    if (step && (phase == PH_DATA)) begin
      if (payload_count == P_LO_CNT) pitch_lo <= rx_byte;
      if (payload_count == P_HI_CNT) pitch_hi <= rx_byte;
      if (payload_count == R_LO_CNT) roll_lo  <= rx_byte;
      if (payload_count == R_HI_CNT) roll_hi  <= rx_byte;
    end
  end

  assign angles.pitch = {pitch_hi[3:0], pitch_lo};
  assign angles.roll  = {roll_hi[3:0], roll_lo};

endmodule

// ===== rtl/gimbal_status_frame_parser.sv =====
// top level of the gimbal status frame parser: input stage, fsm, result register
// depends on gsfp_pkg, gsfp_frame_fsm and assert_macros.svh
//
//   channel   signals                          direction  carries
//   in        in_valid in_ready rx_byte        sink       one received byte
//   out       out_valid out_ready pitch_code   source     angle codes of a
//             roll_code                                   frame with good sum
//
// one byte per cycle sustained unless a result is held by a low out_ready: a byte
// is registered on its transaction, the fsm processes it when the input stage
// advances, and a good checksum loads the result register and sets out_valid.
// rst is synchronous, active high; it clears the parser and both valid flags.
// a result held by a low out_ready stalls the input stage only once a further
// byte is waiting behind it; otherwise bytes keep flowing.
`include "assert_macros.svh"

module gimbal_status_frame_parser #(
  parameter int unsigned PAYLOAD_LEN = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [7:0]                            rx_byte,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [gsfp_pkg::ANGLE_W-1:0]   pitch_code,
  output logic signed [gsfp_pkg::ANGLE_W-1:0]   roll_code
);
  import gsfp_pkg::*;

  // input stage
  logic       byte_valid;
  logic [7:0] byte_q;
  // fsm handshake
  logic       advance;
  fsm_stat_t  stat;
  angles_t    angles;

  // the stored byte moves on when the result register can take a result
  assign advance  = byte_valid && (!out_valid || out_ready);
  assign in_ready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= rx_byte;
    end
  end

  gsfp_frame_fsm #(
    .PAYLOAD_LEN (PAYLOAD_LEN)
  ) u_fsm (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (byte_q),
    .stat    (stat),
    .angles  (angles)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && stat.hit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stat.hit) begin
      pitch_code <= angles.pitch;
      roll_code  <= angles.roll;
    end
  end

  // a waiting byte is held until the fsm takes it
  `ASSERT_NEXT(a_byte_held, clk, rst, byte_valid && !advance, byte_valid && $stable(byte_q))
  // a new result only follows a checksum byte
  `ASSERT_IMPL(a_result_after_csum, clk, rst, $rose(out_valid), $past(stat.in_csum))
  // the checksum phase takes exactly one byte
  `ASSERT_NEXT(a_csum_one_byte, clk, rst, advance && stat.in_csum, !stat.in_csum)

endmodule

// ===== tb/tb_gimbal_status_frame_parser.sv =====
// self-checking testbench for gimbal_status_frame_parser: directed frame table, then random
// byte streams scored against a cycle-free frame predictor; depends on gsfp_pkg and the rtl
`timescale 1ns / 1ps

module tb_gimbal_status_frame_parser;
  import gsfp_pkg::*;

  localparam int unsigned PAYLOAD_LEN  = 16;
  localparam int          RANDOM_ITEMS = 1000;
  localparam int          HOLD_AT      = 300;  // bytes taken before the long receiver hold-off
  localparam int          HOLD_CYCLES  = 300;
  localparam int          CALM_FROM    = 500;  // span of bytes with no idling on either side
  localparam int          CALM_TO      = 700;
  localparam int          DRAIN_CYCLES = 10;   // a result is registered behind its byte
  localparam int          STALL_LIMIT  = 3000; // cycles with no transaction on any channel
  localparam int          DIR_ROWS     = 24;

  typedef struct packed {
    logic [7:0]        b;
    logic              typed;  // row carries its own expected angles
    logic signed [11:0] pitch;
    logic signed [11:0] roll;
  } stim_row_t;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        in_valid;
  logic                        in_ready;
  logic [7:0]                  rx_byte;
  logic                        out_valid;
  logic                        out_ready;
  logic signed [ANGLE_W-1:0]   pitch_code;
  logic signed [ANGLE_W-1:0]   roll_code;

  // expected angles offered with the current transaction
  logic                        row_typed;
  angles_t                     row_want;

  // frame predictor state
  phase_t                      fr_phase = PH_HUNT1;
  logic [4:0]                  fr_count = '0;
  logic [7:0]                  fr_sum = '0;
  logic [7:0]                  fr_angle [4];  // payload bytes from pitch lo to roll hi

  angles_t                     pending_angles [$];
  logic [7:0]                  tx_bytes [$];
  int                          bytes_taken = 0;
  int                          err_count = 0;
  int                          stall_cycles = 0;
  bit                          holding = 1'b0;
  bit                          hold_done = 1'b0;
  logic                        calm;

  assign calm = (bytes_taken >= CALM_FROM) && (bytes_taken < CALM_TO);

  // one frame by hand: noise, both header mismatch cases, angle extremes
  // (pitch +2047 with junk in the high nibble, roll -2048), good sum, stray byte
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{HDR_BYTE_THREE, 1'b0, 12'sd0, 12'sd0},  // ignored while hunting byte one
    '{HDR_BYTE_ONE,   1'b0, 12'sd0, 12'sd0},
    '{8'h00,          1'b0, 12'sd0, 12'sd0},  // wrong second byte, keep waiting
    '{HDR_BYTE_TWO,   1'b0, 12'sd0, 12'sd0},
    '{HDR_BYTE_ONE,   1'b0, 12'sd0, 12'sd0},  // wrong third byte, keep waiting
    '{HDR_BYTE_THREE, 1'b0, 12'sd0, 12'sd0},
    '{HDR_BYTE_ONE,   1'b0, 12'sd0, 12'sd0},  // header value inside the payload
    '{8'h00,          1'b0, 12'sd0, 12'sd0},
    '{8'h00,          1'b0, 12'sd0, 12'sd0},
    '{8'h00,          1'b0, 12'sd0, 12'sd0},
    '{8'h00,          1'b0, 12'sd0, 12'sd0},
    '{8'h00,          1'b0, 12'sd0, 12'sd0},
    '{8'hff,          1'b0, 12'sd0, 12'sd0},  // pitch lo
    '{8'hf7,          1'b0, 12'sd0, 12'sd0},  // pitch hi, upper nibble dropped
    '{8'h00,          1'b0, 12'sd0, 12'sd0},  // roll lo
    '{8'h08,          1'b0, 12'sd0, 12'sd0},  // roll hi
    '{8'h00,          1'b0, 12'sd0, 12'sd0},
    '{8'h00,          1'b0, 12'sd0, 12'sd0},
    '{8'h00,          1'b0, 12'sd0, 12'sd0},
    '{8'h00,          1'b0, 12'sd0, 12'sd0},
    '{8'h00,          1'b0, 12'sd0, 12'sd0},
    '{HDR_BYTE_TWO,   1'b0, 12'sd0, 12'sd0},
    '{8'h23,          1'b1, 12'sd2047, -12'sd2048},  // good checksum
    '{HDR_BYTE_TWO,   1'b0, 12'sd0, 12'sd0}   // back in the hunt, ignored
  };

  gimbal_status_frame_parser #(
    .PAYLOAD_LEN(PAYLOAD_LEN)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pitch_code(pitch_code),
    .roll_code (roll_code)
  );

  always #5 clk = ~clk;

  // advance the frame predictor by one byte; returns 1 when a frame completes with a good sum
  function automatic bit parse_byte(input logic [7:0] b, output angles_t got);
    got = '0;
    parse_byte = 1'b0;
    case (fr_phase)
      PH_HUNT2: begin
        if (b == HDR_BYTE_TWO) begin
          fr_sum += b;
          fr_phase = PH_HUNT3;
        end
      end
      PH_HUNT3: begin
        if (b == HDR_BYTE_THREE) begin
          fr_sum += b;
          fr_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        if (fr_count >= PITCH_LO_POS && fr_count <= ROLL_HI_POS)
          fr_angle[2'(fr_count - PITCH_LO_POS)] = b;
        fr_sum += b;
        fr_count++;
        if (fr_count == PAYLOAD_LEN) fr_phase = PH_CSUM;
      end
      PH_CSUM: begin
        fr_phase = PH_HUNT1;
        if (b == fr_sum) begin
          got.pitch = {fr_angle[2'(PITCH_HI_POS - PITCH_LO_POS)][3:0],
                       fr_angle[2'(PITCH_LO_POS - PITCH_LO_POS)]};
          got.roll  = {fr_angle[2'(ROLL_HI_POS - PITCH_LO_POS)][3:0],
                       fr_angle[2'(ROLL_LO_POS - PITCH_LO_POS)]};
          parse_byte = 1'b1;
        end
      end
      default: begin
        if (b == HDR_BYTE_ONE) begin
          fr_count = '0;
          fr_sum = b;
          fr_phase = PH_HUNT2;
        end
      end
    endcase
  endfunction

  // mostly well-formed frames with random content; some noise, header slips,
  // truncated payloads and bad sums
  task automatic queue_frame();
    logic [7:0] body [PAYLOAD_LEN];
    logic [7:0] sum;
    int         keep;
    int         noise;
    noise = ($urandom_range(99) < 15) ? $urandom_range(3, 1) : 0;
    repeat (noise) tx_bytes.push_back(8'($urandom_range(255)));
    tx_bytes.push_back(HDR_BYTE_ONE);
    if ($urandom_range(99) < 10) tx_bytes.push_back(8'($urandom_range(255)));
    tx_bytes.push_back(HDR_BYTE_TWO);
    if ($urandom_range(99) < 10) tx_bytes.push_back(8'($urandom_range(255)));
    tx_bytes.push_back(HDR_BYTE_THREE);
    sum = HDR_BYTE_ONE + HDR_BYTE_TWO + HDR_BYTE_THREE;
    foreach (body[i]) body[i] = 8'($urandom_range(255));
    if ($urandom_range(99) < 25) begin
      // set both angles near their limits: high nibble 7 or 8, low byte ff or 00
      body[PITCH_LO_POS] = $urandom_range(1) ? 8'hff : 8'h00;
      body[PITCH_HI_POS] = {4'($urandom_range(15)), ($urandom_range(1) ? 4'h7 : 4'h8)};
      body[ROLL_LO_POS]  = $urandom_range(1) ? 8'hff : 8'h00;
      body[ROLL_HI_POS]  = {4'($urandom_range(15)), ($urandom_range(1) ? 4'h7 : 4'h8)};
    end
    keep = ($urandom_range(99) < 8) ? $urandom_range(PAYLOAD_LEN - 1) : PAYLOAD_LEN;
    for (int i = 0; i < keep; i++) begin
      tx_bytes.push_back(body[i]);
      sum += body[i];
    end
    if (keep == PAYLOAD_LEN)
      tx_bytes.push_back(($urandom_range(99) < 80) ? sum : sum ^ 8'($urandom_range(255, 1)));
  endtask

  // offer one byte, possibly after an idle gap, and hold it until the transaction
  task automatic offer_byte(input logic [7:0] b, input logic typed, input angles_t want);
    while (!calm && !holding && $urandom_range(99) < 33) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    rx_byte = b;
    row_typed = typed;
    row_want = want;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // sender and end of run
  initial begin
    logic [7:0] b;
    int         random_sent;
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = '0;
    row_typed = 1'b0;
    row_want = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i])
      offer_byte(dir_rows[i].b, dir_rows[i].typed, {dir_rows[i].pitch, dir_rows[i].roll});

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (tx_bytes.size() == 0) queue_frame();
      b = tx_bytes.pop_front();
      offer_byte(b, 1'b0, '0);
      random_sent++;
    end
    in_valid = 1'b0;

    while (pending_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // receiver: random stalls, one long hold-off so the parser backs up into its input
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!hold_done && bytes_taken >= HOLD_AT) begin
        hold_done = 1'b1;
        holding = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holding = 1'b0;
      end
      out_ready = calm || ($urandom_range(99) >= 33);
      @(negedge clk);
    end
  end

  // score both channels at the rising edge; watchdog on lack of progress
  always @(posedge clk) begin
    angles_t got;
    angles_t want;
    bit      hit;
    if (!rst) begin
      if (in_valid && in_ready) begin
        bytes_taken++;
        hit = parse_byte(rx_byte, got);
        if (row_typed) pending_angles.push_back(row_want);
        else if (hit) pending_angles.push_back(got);
      end

      if (out_valid && out_ready) begin
        if (pending_angles.size() == 0) begin
          $error("unexpected result: pitch_code %0d roll_code %0d", pitch_code, roll_code);
          err_count++;
        end else begin
          want = pending_angles.pop_front();
          if (pitch_code !== want.pitch) begin
            $error("pitch_code: expected %0d, got %0d", want.pitch, pitch_code);
            err_count++;
          end
          if (roll_code !== want.roll) begin
            $error("roll_code: expected %0d, got %0d", want.roll, roll_code);
            err_count++;
          end
        end
      end

      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule
